// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- src/rvx_pkg.sv -----
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared widths, opcodes, function codes and sideband types of the execute unit.
// ----------------------------------------------------------------------------
package rvx_pkg;

  localparam int XLEN = 32;
  // divider depth: one quotient bit per stage
  localparam int DIV_STAGES = XLEN;

  // major opcodes
  localparam logic [6:0] OP_R      = 7'h33;
  localparam logic [6:0] OP_IALU   = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;

  // funct7 codes
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MUL  = 7'h01;

  // ALU funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // M-extension funct3
  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // which unit supplies the final result
  typedef enum logic [2:0] {
    K_PLAIN,
    K_MUL_LO,
    K_MUL_HI,
    K_DIV,
    K_REM
  } kind_t;

  // per-beat sideband carried alongside the divider
  typedef struct packed {
    logic [XLEN-1:0] res;
    logic            redir;
    logic [XLEN-1:0] tgt;
    kind_t           kind;
    logic            negq;
    logic            negr;
  } side_t;

endpackage

// ----- src/rvx_div.sv -----
// ----------------------------------------------------------------------------
// rvx_div
// Fully pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rvx_div #(
  parameter int W = rvx_pkg::XLEN
) (
  input  logic         clk,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  // one shift-and-subtract per stage
  for (genvar k = 1; k <= W; k++) begin : g_stage
    logic [W-1:0] rem_p, quo_p, dvs_p;
    logic [W-1:0] rem_r, quo_r;
    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         ge;

    // stage one takes the operands straight from the ports
    if (k == 1) begin : g_first
      assign rem_p = '0;
      assign quo_p = dividend;
      assign dvs_p = divisor;
    end else begin : g_next
      assign rem_p = g_stage[k-1].rem_r;
      assign quo_p = g_stage[k-1].quo_r;
      assign dvs_p = g_stage[k-1].g_dvs.dvs_r;
    end

    assign shifted = {rem_p, quo_p[W-1]};
    assign diff    = shifted - {1'b0, dvs_p};
    assign ge      = ~diff[W];

    always_ff @(posedge clk) begin
      rem_r <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo_r <= {quo_p[W-2:0], ge};
    end

    // divisor travels along with the beat; the last stage needs no copy
    if (k < W) begin : g_dvs
      logic [W-1:0] dvs_r;
      always_ff @(posedge clk) begin
        dvs_r <= dvs_p;
      end
    end
  end

  assign quotient  = g_stage[W].quo_r;
  assign remainder = g_stage[W].rem_r;

endmodule

// ----- src/rv32im_execute_unit_core.sv -----
// ----------------------------------------------------------------------------
// rv32im_execute_unit_core
// RV32IM execute stage: ALU, branch/jump resolution, multiply and divide.
// ----------------------------------------------------------------------------
// A start beat passes the input register, the ALU stage register, the delay
// line and output register before its result strobe, for every instruction.
// Throughput: one instruction per cycle; busy is always low.
// The depth is set by the divider, which retires one quotient bit per stage.
// Reset (rst_n low, synchronous) clears all valid bits; no result strobes
// until new instructions arrive. The receiver cannot stall the pipeline.
`include "assert_macros.svh"

module rv32im_execute_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [6:0]  in_mode,
  input  logic [2:0]  in_funct3,
  input  logic [6:0]  in_funct7,
  input  logic signed [31:0] in_immediate,
  input  logic [31:0] in_pc_value,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic        out_valid,
  output logic signed [31:0] out_alu_result,
  output logic        out_redirect,
  output logic [31:0] out_target_address
);

  localparam int XW = rvx_pkg::XLEN;
  localparam int DS = rvx_pkg::DIV_STAGES;

  assign busy = 1'b0;

  // ---- stage 1: input register ----
  logic          v1_r;
  logic [6:0]    mode1_r, f71_r;
  logic [2:0]    f31_r;
  logic [XW-1:0] imm1_r, pc1_r, a1_r, b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    mode1_r <= in_mode;
    f31_r   <= in_funct3;
    f71_r   <= in_funct7;
    imm1_r  <= in_immediate;
    pc1_r   <= in_pc_value;
    a1_r    <= in_operand_a;
    b1_r    <= in_operand_b;
  end

  // ---- stage 2: ALU, branch, multiply, divider operand prep ----
  rvx_pkg::side_t  side2_nxt, side2_r;
  logic            sa, sb, dsig;
  logic [XW-1:0]   sum_ai, sum_pi, pc4, sr_imm, sra_imm;
  logic [XW-1:0]   mag_a_nxt, mag_b_nxt, mag_a_r, mag_b_r;
  logic [6:0]      ihi;
  logic [4:0]      shb, shi;
  logic            lt_s, lt_u, take;
  logic signed [2*XW+1:0] prod_nxt, prod_r;
  logic            v2_r;

  always_comb begin
    sum_ai  = a1_r + imm1_r;
    sum_pi  = pc1_r + imm1_r;
    pc4     = pc1_r + XW'(4);
    shb     = b1_r[4:0];
    shi     = imm1_r[4:0];
    ihi     = imm1_r[11:5];
    sr_imm  = a1_r >> shi;
    sra_imm = XW'($signed(a1_r) >>> shi);
    lt_s    = $signed(a1_r) < $signed(b1_r);
    lt_u    = a1_r < b1_r;
    sa      = 1'b0;
    sb      = 1'b0;
    dsig    = 1'b0;
    take    = 1'b0;
    side2_nxt = '{res: '0, redir: 1'b0, tgt: '0, kind: rvx_pkg::K_PLAIN,
                  negq: 1'b0, negr: 1'b0};
    unique case (mode1_r)
      rvx_pkg::OP_R: begin
        if (f71_r == rvx_pkg::F7_MUL) begin
          unique case (f31_r)
            rvx_pkg::F3_MUL:    side2_nxt.kind = rvx_pkg::K_MUL_LO;
            rvx_pkg::F3_MULH: begin
              side2_nxt.kind = rvx_pkg::K_MUL_HI; sa = 1'b1; sb = 1'b1;
            end
            rvx_pkg::F3_MULHSU: begin
              side2_nxt.kind = rvx_pkg::K_MUL_HI; sa = 1'b1;
            end
            rvx_pkg::F3_MULHU:  side2_nxt.kind = rvx_pkg::K_MUL_HI;
            rvx_pkg::F3_DIV: begin
              side2_nxt.kind = rvx_pkg::K_DIV; dsig = 1'b1;
            end
            rvx_pkg::F3_DIVU:   side2_nxt.kind = rvx_pkg::K_DIV;
            rvx_pkg::F3_REM: begin
              side2_nxt.kind = rvx_pkg::K_REM; dsig = 1'b1;
            end
            default:            side2_nxt.kind = rvx_pkg::K_REM;
          endcase
        end else if (f71_r == rvx_pkg::F7_ALT) begin
          if (f31_r == rvx_pkg::F3_ADD) side2_nxt.res = a1_r - b1_r;
          else if (f31_r == rvx_pkg::F3_SR)
            side2_nxt.res = XW'($signed(a1_r) >>> shb);
        end else if (f71_r == rvx_pkg::F7_BASE) begin
          unique case (f31_r)
            rvx_pkg::F3_ADD:  side2_nxt.res = a1_r + b1_r;
            rvx_pkg::F3_SLL:  side2_nxt.res = a1_r << shb;
            rvx_pkg::F3_SLT:  side2_nxt.res = {{(XW-1){1'b0}}, lt_s};
            rvx_pkg::F3_SLTU: side2_nxt.res = {{(XW-1){1'b0}}, lt_u};
            rvx_pkg::F3_XOR:  side2_nxt.res = a1_r ^ b1_r;
            rvx_pkg::F3_SR:   side2_nxt.res = a1_r >> shb;
            rvx_pkg::F3_OR:   side2_nxt.res = a1_r | b1_r;
            default:          side2_nxt.res = a1_r & b1_r;
          endcase
        end
      end
      rvx_pkg::OP_IALU: begin
        unique case (f31_r)
          rvx_pkg::F3_ADD: side2_nxt.res = sum_ai;
          rvx_pkg::F3_SLL:
            side2_nxt.res = (ihi == rvx_pkg::F7_BASE) ? (a1_r << shi) : '0;
          rvx_pkg::F3_SLT:
            side2_nxt.res = {{(XW-1){1'b0}}, $signed(a1_r) < $signed(imm1_r)};
          rvx_pkg::F3_SLTU:
            side2_nxt.res = {{(XW-1){1'b0}}, a1_r < imm1_r};
          rvx_pkg::F3_XOR: side2_nxt.res = a1_r ^ imm1_r;
          rvx_pkg::F3_SR: begin
            if (ihi == rvx_pkg::F7_BASE)     side2_nxt.res = sr_imm;
            else if (ihi == rvx_pkg::F7_ALT) side2_nxt.res = sra_imm;
          end
          rvx_pkg::F3_OR:  side2_nxt.res = a1_r | imm1_r;
          default:         side2_nxt.res = a1_r & imm1_r;
        endcase
      end
      rvx_pkg::OP_LOAD, rvx_pkg::OP_STORE: side2_nxt.res = sum_ai;
      rvx_pkg::OP_LUI:   side2_nxt.res = imm1_r;
      rvx_pkg::OP_AUIPC: side2_nxt.res = sum_pi;
      rvx_pkg::OP_JAL: begin
        side2_nxt.res   = pc4;
        side2_nxt.tgt   = sum_pi;
        side2_nxt.redir = 1'b1;
      end
      rvx_pkg::OP_JALR: begin
        if (f31_r == rvx_pkg::F3_ADD) begin
          side2_nxt.res   = pc4;
          side2_nxt.tgt   = {sum_ai[XW-1:1], 1'b0};
          side2_nxt.redir = 1'b1;
        end
      end
      rvx_pkg::OP_BRANCH: begin
        case (f31_r)
          rvx_pkg::F3_BEQ:  take = (a1_r == b1_r);
          rvx_pkg::F3_BNE:  take = (a1_r != b1_r);
          rvx_pkg::F3_BLT:  take = lt_s;
          rvx_pkg::F3_BGE:  take = ~lt_s;
          rvx_pkg::F3_BLTU: take = lt_u;
          rvx_pkg::F3_BGEU: take = ~lt_u;
          default:          take = 1'b0;
        endcase
        if (f31_r != rvx_pkg::F3_SLT && f31_r != rvx_pkg::F3_SLTU) begin
          side2_nxt.tgt   = sum_pi;
          side2_nxt.redir = take;
        end
      end
      default: ;
    endcase

    // divider operand magnitudes and sign fixups
    mag_a_nxt = (dsig & a1_r[XW-1]) ? (XW'(0) - a1_r) : a1_r;
    mag_b_nxt = (dsig & b1_r[XW-1]) ? (XW'(0) - b1_r) : b1_r;
    side2_nxt.negq = dsig & (a1_r[XW-1] ^ b1_r[XW-1]) & (b1_r != '0);
    side2_nxt.negr = dsig & a1_r[XW-1];

    // one signed 33x33 multiply covers all four variants
    prod_nxt = $signed({sa & a1_r[XW-1], a1_r}) * $signed({sb & b1_r[XW-1], b1_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    side2_r <= side2_nxt;
    mag_a_r <= mag_a_nxt;
    mag_b_r <= mag_b_nxt;
    prod_r  <= prod_nxt;
  end

  // ---- divider, aligned with the sideband delay line ----
  logic [XW-1:0] quo, rmd;

  rvx_div #(.W(XW)) u_div (
    .clk       (clk),
    .dividend  (mag_a_r),
    .divisor   (mag_b_r),
    .quotient  (quo),
    .remainder (rmd)
  );

  rvx_pkg::side_t dl_r [0:DS-1];
  logic           dv_r [0:DS-1];
  rvx_pkg::side_t dl_in;

  // fold the multiply result into the beat as it enters the line
  always_comb begin
    dl_in = side2_r;
    case (side2_r.kind)
      rvx_pkg::K_MUL_LO: dl_in.res = prod_r[XW-1:0];
      rvx_pkg::K_MUL_HI: dl_in.res = prod_r[2*XW-1:XW];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DS; i++) dv_r[i] <= 1'b0;
    end else begin
      dv_r[0] <= v2_r;
      for (int i = 1; i < DS; i++) dv_r[i] <= dv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    dl_r[0] <= dl_in;
    for (int i = 1; i < DS; i++) dl_r[i] <= dl_r[i-1];
  end

  // ---- output stage: divide sign fixup and final select ----
  rvx_pkg::side_t last;
  logic [XW-1:0]  res_nxt;
  logic           ov_r;
  logic [XW-1:0]  ores_r, otgt_r;
  logic           oredir_r;

  always_comb begin
    last = dl_r[DS-1];
    case (last.kind)
      rvx_pkg::K_DIV: res_nxt = last.negq ? (XW'(0) - quo) : quo;
      rvx_pkg::K_REM: res_nxt = last.negr ? (XW'(0) - rmd) : rmd;
      default:        res_nxt = last.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r     <= 1'b0;
      oredir_r <= 1'b0;
    end else begin
      ov_r     <= dv_r[DS-1];
      oredir_r <= dv_r[DS-1] & last.redir;
    end
  end

  always_ff @(posedge clk) begin
    ores_r <= res_nxt;
    otgt_r <= last.tgt;
  end

  assign out_valid          = ov_r;
  assign out_alu_result     = ores_r;
  assign out_redirect       = oredir_r;
  assign out_target_address = otgt_r;

  // ---- assertions ----
  `ASSERT_AT(a_out_from_start, clk, rst_n, out_valid |-> $past(start, DS + 3))
  `ASSERT_AT(a_redir_valid, clk, rst_n, out_redirect |-> out_valid)
  `ASSERT_AT(a_s2_from_s1, clk, rst_n, v2_r |-> $past(v1_r))
  `ASSERT_NEVER(a_no_busy, clk, rst_n, busy)

endmodule
